/* rtl/core/mmnb_pkg.sv */
// Shared constants for the min-max contrast stretch block.
`default_nettype none
package mmnb_pkg;
	localparam int unsigned PIX_W = 8;
	localparam logic [PIX_W-1:0] PIX_MAX_RESET = 8'd255;
endpackage
`default_nettype wire

/* rtl/core/min_max_normalize_to_byte_core.sv */
// Min-max contrast stretch core: frame statistics and byte conversion with a serial divider.
//
// A frame is sent twice. Scan transactions (mode 0) update the running minimum
// and maximum in the cycle they are accepted and give no result; first_of_frame
// restarts both at that sample. Convert transactions (mode 1) give one byte,
// floor(peak*(sample-min)/(max-min)), where peak is the configured full-scale
// byte, saturating to 0 or peak outside the scanned range, and 0 for a flat
// frame. A convert that needs the divide forms offset and range on acceptance,
// multiplies in ST_MUL, then in ST_DIV takes one restoring step per bit of the
// SAMPLE_BITS+8 bit product through the single shared subtractor, and in
// ST_FINISH loads the output register once the output is free. Saturated or
// flat converts go straight to ST_FINISH. in_stall is high while a convert is
// in progress. The result register lets the next sample be accepted while a
// byte still waits on out_stall. The peak byte is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce.
`default_nettype none
module min_max_normalize_to_byte_core #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [mmnb_pkg::PIX_W-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          mode,
	input  wire logic                          first_of_frame,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [mmnb_pkg::PIX_W-1:0]         pixel_byte
);
	localparam int unsigned PW     = mmnb_pkg::PIX_W;
	localparam int unsigned PROD_W = SAMPLE_BITS + PW;
	localparam int unsigned CNT_W  = $clog2(PROD_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic signed [SAMPLE_BITS-1:0]  min_q;
	logic signed [SAMPLE_BITS-1:0]  max_q;
	logic [PW-1:0]                  pixmax_q;
	logic [SAMPLE_BITS-1:0]         offs_q;
	logic [SAMPLE_BITS-1:0]         range_q;
	logic [PROD_W-1:0]              prod_q;
	logic [SAMPLE_BITS-1:0]         rem_q;
	logic [PW-1:0]                  quo_q;
	logic                           out_valid_q;
	logic [PW-1:0]                  pixel_byte_q;

	logic                           accept;
	logic signed [SAMPLE_BITS:0]    offs_full;
	logic [SAMPLE_BITS-1:0]         range_w;
	logic                           is_low;
	logic                           is_high;
	logic                           is_flat;
	logic [PROD_W-1:0]              product;
	logic [SAMPLE_BITS:0]           shifted;
	logic [SAMPLE_BITS+1:0]         trial;
	logic                           q_bit;
	logic                           out_free;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_byte_q;
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		offs_full = {sample[SAMPLE_BITS-1], sample} - {min_q[SAMPLE_BITS-1], min_q};
		range_w   = max_q - min_q;
		is_flat   = (max_q <= min_q);
		is_low    = offs_full[SAMPLE_BITS] || (offs_full == '0);
		is_high   = (sample >= max_q);
		product   = PROD_W'(pixmax_q) * PROD_W'(offs_q);
		// restoring step: remainder stays below range, so one subtract per bit
		shifted   = {rem_q, prod_q[PROD_W-1]};
		trial     = {1'b0, shifted} - {2'b00, range_q};
		q_bit     = !trial[SAMPLE_BITS+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			pixmax_q    <= mmnb_pkg::PIX_MAX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pixmax_q <= cfg_wr_data;
			end

			if (state_q == ST_FINISH && out_free) begin
				out_valid_q  <= 1'b1;
				pixel_byte_q <= quo_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!mode) begin
							if (first_of_frame) begin
								min_q <= sample;
								max_q <= sample;
							end else if (sample < min_q) begin
								min_q <= sample;
							end else if (sample > max_q) begin
								max_q <= sample;
							end
						end else if (is_flat || is_low) begin
							quo_q   <= '0;
							state_q <= ST_FINISH;
						end else if (is_high) begin
							quo_q   <= pixmax_q;
							state_q <= ST_FINISH;
						end else begin
							offs_q  <= offs_full[SAMPLE_BITS-1:0];
							range_q <= range_w;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= product;
					rem_q   <= '0;
					cnt_q   <= CNT_W'(PROD_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= q_bit ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
					prod_q <= {prod_q[PROD_W-2:0], 1'b0};
					quo_q  <= {quo_q[PW-2:0], q_bit};
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/core/mmnb_checker.sv */
// Port-level checks for the min-max contrast stretch core, with its bind.
`default_nettype none
module mmnb_checker #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cfg_wr_en,
	input wire logic [mmnb_pkg::PIX_W-1:0]    cfg_wr_data,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          mode,
	input wire logic                          first_of_frame,
	input wire logic signed [SAMPLE_BITS-1:0] sample,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [mmnb_pkg::PIX_W-1:0]    pixel_byte
);
	// a held result keeps its byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_byte))
		else $error("result changed while stalled");

	// scan transactions finish in the cycle they are taken
	a_scan_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !mode |=> !in_stall)
		else $error("input stalled after a scan transaction");

	// a convert transaction occupies the core
	a_conv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode |=> in_stall)
		else $error("input not stalled after a convert transaction");

	// a new result only follows convert work in progress
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a convert in progress");
endmodule

bind min_max_normalize_to_byte_core mmnb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mmnb_checker (.*);
`default_nettype wire

/* verif/min_max_normalize_to_byte_core_test.sv */
// Testbench for the min-max contrast stretch core: directed and random frames vs a byte predictor.
module min_max_normalize_to_byte_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SW = 16;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam logic MODE_SCAN = 1'b0;
	localparam logic MODE_CONVERT = 1'b1;

	typedef struct {
		logic                 mode;
		logic                 fof;
		logic signed [SW-1:0] smp;
	} sample_txn_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [mmnb_pkg::PIX_W-1:0]    cfg_wr_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          mode = 1'b0;
	logic                          first_of_frame = 1'b0;
	logic signed [SW-1:0]          sample = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [mmnb_pkg::PIX_W-1:0]    pixel_byte;

	// stimulus and predictor state
	sample_txn_t                   pending[$];
	sample_txn_t                   nxt;
	logic [mmnb_pkg::PIX_W-1:0]    bytes_due[$];
	logic signed [SW-1:0]          run_lo = '0;
	logic signed [SW-1:0]          run_hi = '0;
	logic [mmnb_pkg::PIX_W-1:0]    pix_max = mmnb_pkg::PIX_MAX_RESET;
	int unsigned                   hold_pct = 24;
	int unsigned                   phase_items = 0;
	int unsigned                   bad_bytes = 0;
	int unsigned                   quiet_cycles = 0;
	logic                          in_took = 1'b0;

	min_max_normalize_to_byte_core #(
		.SAMPLE_BITS(SW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.first_of_frame(first_of_frame),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_byte(pixel_byte)
	);

	always #6 clk = ~clk;

	// scan updates the frame statistics, convert queues the byte it must give
	task automatic apply_stretch(input sample_txn_t t);
		longint offs;
		longint span;
		logic [mmnb_pkg::PIX_W-1:0] b;
		if (t.mode == MODE_SCAN) begin
			if (t.fof) begin
				run_lo = t.smp;
				run_hi = t.smp;
			end else if (t.smp < run_lo) begin
				run_lo = t.smp;
			end else if (t.smp > run_hi) begin
				run_hi = t.smp;
			end
		end else begin
			if (run_hi <= run_lo || t.smp <= run_lo) begin
				b = '0;
			end else if (t.smp >= run_hi) begin
				b = pix_max;
			end else begin
				offs = longint'(t.smp) - longint'(run_lo);
				span = longint'(run_hi) - longint'(run_lo);
				b = mmnb_pkg::PIX_W'((longint'(pix_max) * offs) / span);
			end
			bytes_due.push_back(b);
		end
	endtask

	task automatic push_item(input logic m, input logic f, input logic signed [SW-1:0] s);
		sample_txn_t t;
		t.mode = m;
		t.fof = f;
		t.smp = s;
		pending.push_back(t);
		phase_items++;
	endtask

	// one frame scanned and then converted, with occasional broken marks and stray samples
	task automatic queue_frame();
		logic signed [SW-1:0] px[$];
		logic signed [SW-1:0] base;
		int unsigned n;
		int unsigned span;
		int unsigned k;
		n = ($urandom_range(9) == 0) ? $urandom_range(32, 16) : $urandom_range(8, 1);
		case ($urandom_range(2))
			0: span = $urandom_range(3);
			1: span = $urandom_range(400);
			default: span = 65535;
		endcase
		base = SW'($urandom);
		for (k = 0; k < n; k++)
			px.push_back(base + SW'($urandom_range(span)));
		for (k = 0; k < n; k++)
			push_item(MODE_SCAN, (k == 0) ? ($urandom_range(7) != 0) : ($urandom_range(19) == 0),
				px[k]);
		for (k = 0; k < n; k++)
			push_item(MODE_CONVERT, 1'($urandom_range(1)),
				($urandom_range(5) == 0) ? SW'($urandom) : px[k]);
	endtask

	task automatic write_peak(input logic [mmnb_pkg::PIX_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		pix_max = v;
	endtask

	// block is idle once every transaction went in and every byte came out
	task automatic drain();
		while (pending.size() != 0 || in_valid || bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (pending.size() != 0 && $urandom_range(99) >= hold_pct) begin
				nxt = pending.pop_front();
				in_valid <= 1'b1;
				mode <= nxt.mode;
				first_of_frame <= nxt.fof;
				sample <= nxt.smp;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < hold_pct);
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		logic out_took;
		logic [mmnb_pkg::PIX_W-1:0] want;
		in_took = arst_n && in_valid && !in_stall;
		out_took = arst_n && out_valid && !out_stall;
		if (in_took) begin
			nxt.mode = mode;
			nxt.fof = first_of_frame;
			nxt.smp = sample;
			apply_stretch(nxt);
		end
		if (out_took) begin
			if (bytes_due.size() == 0) begin
				bad_bytes++;
				if (bad_bytes <= 10)
					$display("%0t: pixel_byte %0d with no transaction outstanding",
						$realtime, pixel_byte);
			end else begin
				want = bytes_due.pop_front();
				if (pixel_byte !== want) begin
					bad_bytes++;
					if (bad_bytes <= 10)
						$display("%0t: pixel_byte mismatch: expected %0d, got %0d",
							$realtime, want, pixel_byte);
				end
			end
		end
		if (!arst_n || in_took || out_took || cfg_wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [mmnb_pkg::PIX_W-1:0] pm_plan[5];
		logic [mmnb_pkg::PIX_W-1:0] pm;
		int unsigned ph;
		pm_plan = '{8'd1, 8'd0, 8'd128, 8'd0, 8'd255};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset statistics are both zero: flat until scanned
		push_item(MODE_CONVERT, 1'b0, 16'sd0);
		push_item(MODE_CONVERT, 1'b1, 16'sd32767);
		// scan with no frame mark continues from reset values
		push_item(MODE_SCAN, 1'b0, 16'sd100);
		push_item(MODE_CONVERT, 1'b0, 16'sd50);
		push_item(MODE_CONVERT, 1'b0, -16'sd5);
		push_item(MODE_CONVERT, 1'b0, 16'sd0);
		push_item(MODE_CONVERT, 1'b0, 16'sd100);
		push_item(MODE_CONVERT, 1'b0, 16'sd200);
		// full-scale frame
		push_item(MODE_SCAN, 1'b1, -16'sd32768);
		push_item(MODE_SCAN, 1'b0, 16'sd32767);
		push_item(MODE_SCAN, 1'b0, 16'sd0);
		push_item(MODE_CONVERT, 1'b1, -16'sd32768);
		push_item(MODE_CONVERT, 1'b0, 16'sd32767);
		push_item(MODE_CONVERT, 1'b0, 16'sd0);
		push_item(MODE_CONVERT, 1'b0, -16'sd1);
		push_item(MODE_CONVERT, 1'b0, 16'sd32766);
		// flat frame
		push_item(MODE_SCAN, 1'b1, 16'sd1234);
		push_item(MODE_CONVERT, 1'b0, 16'sd1234);
		push_item(MODE_CONVERT, 1'b0, 16'sd2000);
		push_item(MODE_CONVERT, 1'b0, -16'sd10);
		// min then max move inside one frame
		push_item(MODE_SCAN, 1'b1, 16'sd7);
		push_item(MODE_SCAN, 1'b0, 16'sd5);
		push_item(MODE_SCAN, 1'b0, 16'sd9);
		push_item(MODE_CONVERT, 1'b0, 16'sd8);
		push_item(MODE_CONVERT, 1'b0, 16'sd6);
		drain();

		for (ph = 0; ph < 5; ph++) begin
			pm = (ph == 3) ? mmnb_pkg::PIX_W'($urandom_range(254, 2)) : pm_plan[ph];
			write_peak(pm);
			hold_pct = (ph == 2) ? 0 : 24;
			phase_items = 0;
			while (phase_items < 165) begin
				if ($urandom_range(5) == 0)
					push_item(1'($urandom_range(1)), 1'($urandom_range(1)), SW'($urandom));
				else
					queue_frame();
			end
			drain();
		end

		bad_bytes += bytes_due.size();
		if (bad_bytes == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
